// ----- hw/rtl/i2c_master_bit_engine_unit_macros.svh -----
// Assertion helpers used by the bit engine core module.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH
`define I2C_MASTER_BIT_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define I2CMBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define I2CMBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/i2cmbe_pkg.sv -----
package i2cmbe_pkg;

  // command codes
  localparam logic [2:0] FN_START   = 3'd0;
  localparam logic [2:0] FN_STOP    = 3'd1;
  localparam logic [2:0] FN_WRITE   = 3'd2;
  localparam logic [2:0] FN_READ    = 3'd3;
  localparam logic [2:0] FN_RELEASE = 3'd4;

  localparam logic [15:0] HALF_DELAY_RST = 16'd100;
  // last bit index of a byte
  localparam logic [3:0]  BIT_LAST       = 4'd7;

  typedef enum logic [21:0] {
    PH_IDLE     = 22'h000001,
    PH_ST_A     = 22'h000002,
    PH_ST_B     = 22'h000004,
    PH_ST_C     = 22'h000008,
    PH_ST_D     = 22'h000010,
    PH_SP_A     = 22'h000020,
    PH_SP_B     = 22'h000040,
    PH_SP_C     = 22'h000080,
    PH_WR_DATA  = 22'h000100,
    PH_WR_HIGH  = 22'h000200,
    PH_WR_LOW   = 22'h000400,
    PH_WA_REL   = 22'h000800,
    PH_WA_HIGH  = 22'h001000,
    PH_WA_LOW   = 22'h002000,
    PH_RD_HIGH  = 22'h004000,
    PH_RD_LOW   = 22'h008000,
    PH_RA_DRIVE = 22'h010000,
    PH_RA_HIGH  = 22'h020000,
    PH_RA_LOW   = 22'h040000,
    PH_RA_REL   = 22'h080000,
    PH_BR_LOW   = 22'h100000,
    PH_BR_HIGH  = 22'h200000
  } phase_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] func;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       acked;
    logic       release_ok;
  } result_t;

endpackage

// ----- hw/rtl/i2cmbe_in_reg.sv -----
// Input word register; holds one tick word until the core consumes it.
module i2cmbe_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  i2cmbe_pkg::item_t in_item,
  input  logic              adv,
  output logic              step_en,
  output i2cmbe_pkg::item_t item
);

  logic              vld_r, vld_nxt;
  i2cmbe_pkg::item_t item_r;

  assign in_stall = vld_r && !adv;
  assign step_en  = vld_r && adv;
  assign item     = item_r;

  always_comb begin
    vld_nxt = vld_r;
    if (!in_stall) begin
      vld_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

// ----- hw/rtl/i2cmbe_core.sv -----
`include "i2c_master_bit_engine_unit_macros.svh"

// Bit engine state and one-tick update.
module i2cmbe_core #(
  parameter int RELEASE_PULSES = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  input  logic                step_en,
  input  i2cmbe_pkg::item_t   item,
  output i2cmbe_pkg::result_t res
);

  localparam logic [3:0] BR_LAST = 4'(RELEASE_PULSES - 1);

  logic [15:0]        half_delay_r;
  i2cmbe_pkg::phase_t phase_r, ph_nxt, ent_ph;
  logic [15:0]        dly_r, dly_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [7:0]         shf_r, shf_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               ack_r, ack_nxt;
  logic               rel_r, rel_nxt;
  logic [7:0]         rx_r, rx_nxt;
  logic               areq_r, areq_nxt;
  logic               done, ent, fin;

  always_comb begin
    ph_nxt   = phase_r;
    dly_nxt  = dly_r;
    bit_nxt  = bit_r;
    shf_nxt  = shf_r;
    scl_nxt  = scl_r;
    sda_nxt  = sda_r;
    ack_nxt  = ack_r;
    rel_nxt  = rel_r;
    rx_nxt   = rx_r;
    areq_nxt = areq_r;
    done     = 1'b0;
    ent      = 1'b0;
    ent_ph   = i2cmbe_pkg::PH_IDLE;
    fin      = 1'b0;

    priority if (phase_r == i2cmbe_pkg::PH_IDLE) begin
      if (item.cmd_valid) begin
        bit_nxt = '0;
        unique case (item.func)
          i2cmbe_pkg::FN_START: begin
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_ST_A;
          end
          i2cmbe_pkg::FN_STOP: begin
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_SP_A;
          end
          i2cmbe_pkg::FN_WRITE: begin
            shf_nxt = item.tx_byte;
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_WR_DATA;
          end
          i2cmbe_pkg::FN_READ: begin
            areq_nxt = item.send_ack;
            shf_nxt  = '0;
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_RD_HIGH;
          end
          i2cmbe_pkg::FN_RELEASE: begin
            if (item.sda_in) begin
              rel_nxt = 1'b1;
              done    = 1'b1;
            end else begin
              ent = 1'b1; ent_ph = i2cmbe_pkg::PH_BR_LOW;
            end
          end
          default: ;
        endcase
      end
    end else if (dly_r != '0) begin
      dly_nxt = dly_r - 16'd1;
    end else begin
      unique case (phase_r)
        i2cmbe_pkg::PH_ST_A:    begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_ST_B; end
        i2cmbe_pkg::PH_ST_B:    begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_ST_C; end
        i2cmbe_pkg::PH_ST_C:    begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_ST_D; end
        i2cmbe_pkg::PH_SP_A:    begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_SP_B; end
        i2cmbe_pkg::PH_SP_B:    begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_SP_C; end
        i2cmbe_pkg::PH_WR_DATA: begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_WR_HIGH; end
        i2cmbe_pkg::PH_WR_HIGH: begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_WR_LOW; end
        i2cmbe_pkg::PH_WR_LOW: begin
          shf_nxt = {shf_r[6:0], 1'b0};
          ent = 1'b1;
          if (bit_r >= i2cmbe_pkg::BIT_LAST) begin
            bit_nxt = '0;
            ent_ph  = i2cmbe_pkg::PH_WA_REL;
          end else begin
            bit_nxt = bit_r + 4'd1;
            ent_ph  = i2cmbe_pkg::PH_WR_DATA;
          end
        end
        i2cmbe_pkg::PH_WA_REL:  begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_WA_HIGH; end
        i2cmbe_pkg::PH_WA_HIGH: begin
          ack_nxt = !item.sda_in;
          ent = 1'b1; ent_ph = i2cmbe_pkg::PH_WA_LOW;
        end
        i2cmbe_pkg::PH_RD_HIGH: begin
          shf_nxt = {shf_r[6:0], item.sda_in};
          ent = 1'b1; ent_ph = i2cmbe_pkg::PH_RD_LOW;
        end
        i2cmbe_pkg::PH_RD_LOW: begin
          ent = 1'b1;
          if (bit_r >= i2cmbe_pkg::BIT_LAST) begin
            bit_nxt = '0;
            rx_nxt  = shf_r;
            ent_ph  = i2cmbe_pkg::PH_RA_DRIVE;
          end else begin
            bit_nxt = bit_r + 4'd1;
            ent_ph  = i2cmbe_pkg::PH_RD_HIGH;
          end
        end
        i2cmbe_pkg::PH_RA_DRIVE: begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_RA_HIGH; end
        i2cmbe_pkg::PH_RA_HIGH:  begin ent = 1'b1; ent_ph = i2cmbe_pkg::PH_RA_LOW; end
        i2cmbe_pkg::PH_RA_LOW: begin
          // the release phase follows an ACK only
          if (areq_r) begin
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_RA_REL;
          end else begin
            fin = 1'b1;
          end
        end
        i2cmbe_pkg::PH_BR_LOW: begin
          if (item.sda_in) begin
            rel_nxt = 1'b1;
            fin     = 1'b1;
          end else begin
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_BR_HIGH;
          end
        end
        i2cmbe_pkg::PH_BR_HIGH: begin
          if (bit_r >= BR_LAST) begin
            rel_nxt = 1'b0;
            fin     = 1'b1;
          end else begin
            bit_nxt = bit_r + 4'd1;
            ent = 1'b1; ent_ph = i2cmbe_pkg::PH_BR_LOW;
          end
        end
        default: fin = 1'b1;   // end of start, stop, write ack and read ack release
      endcase
    end

    if (fin) begin
      ph_nxt  = i2cmbe_pkg::PH_IDLE;
      dly_nxt = '0;
      bit_nxt = '0;
      done    = 1'b1;
    end

    if (ent) begin
      ph_nxt  = ent_ph;
      dly_nxt = half_delay_r;
      unique case (ent_ph)
        i2cmbe_pkg::PH_ST_A, i2cmbe_pkg::PH_SP_C,
        i2cmbe_pkg::PH_WA_REL, i2cmbe_pkg::PH_RA_REL: sda_nxt = 1'b1;
        i2cmbe_pkg::PH_ST_C, i2cmbe_pkg::PH_SP_A:     sda_nxt = 1'b0;
        i2cmbe_pkg::PH_ST_B, i2cmbe_pkg::PH_SP_B, i2cmbe_pkg::PH_WR_HIGH,
        i2cmbe_pkg::PH_WA_HIGH, i2cmbe_pkg::PH_RA_HIGH,
        i2cmbe_pkg::PH_BR_HIGH:                       scl_nxt = 1'b1;
        i2cmbe_pkg::PH_ST_D, i2cmbe_pkg::PH_WR_LOW, i2cmbe_pkg::PH_WA_LOW,
        i2cmbe_pkg::PH_RD_LOW, i2cmbe_pkg::PH_RA_LOW,
        i2cmbe_pkg::PH_BR_LOW:                        scl_nxt = 1'b0;
        i2cmbe_pkg::PH_WR_DATA:                       sda_nxt = shf_nxt[7];
        i2cmbe_pkg::PH_RD_HIGH: begin
          sda_nxt = 1'b1;
          scl_nxt = 1'b1;
        end
        i2cmbe_pkg::PH_RA_DRIVE:                      sda_nxt = !areq_nxt;
        default: ;
      endcase
    end
  end

  always_comb begin
    res.scl_out    = scl_nxt;
    res.sda_out    = sda_nxt;
    res.ready_res  = (ph_nxt == i2cmbe_pkg::PH_IDLE);
    res.done_res   = done;
    res.rx_byte    = rx_nxt;
    res.acked      = ack_nxt;
    res.release_ok = rel_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_delay_r <= i2cmbe_pkg::HALF_DELAY_RST;
    end else if (cfg_wr_en) begin
      half_delay_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cmbe_pkg::PH_IDLE;
      dly_r   <= '0;
      bit_r   <= '0;
      shf_r   <= '0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      rel_r   <= 1'b0;
      rx_r    <= '0;
      areq_r  <= 1'b0;
    end else if (step_en) begin
      phase_r <= ph_nxt;
      dly_r   <= dly_nxt;
      bit_r   <= bit_nxt;
      shf_r   <= shf_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      rel_r   <= rel_nxt;
      rx_r    <= rx_nxt;
      areq_r  <= areq_nxt;
    end
  end

  `I2CMBE_ASSERT_IMP(a_idle_clean, phase_r == i2cmbe_pkg::PH_IDLE, (dly_r == '0) && (bit_r == '0), "idle with live counters")
  `I2CMBE_ASSERT_IMP(a_done_ready, step_en && res.done_res, res.ready_res, "done without going idle")
  `I2CMBE_ASSERT_NXT(a_hold_state, !step_en, $stable(phase_r) && $stable(dly_r) && $stable(shf_r), "state moved without a tick")
  `I2CMBE_ASSERT_IMP(a_byte_bits, (phase_r == i2cmbe_pkg::PH_WR_LOW) || (phase_r == i2cmbe_pkg::PH_RD_LOW), bit_r <= i2cmbe_pkg::BIT_LAST, "byte bit count overrun")

endmodule

// ----- hw/rtl/i2cmbe_out_reg.sv -----
// Result word register; takes a new word whenever it is empty or being taken.
module i2cmbe_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step_en,
  input  i2cmbe_pkg::result_t res,
  output logic                adv,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cmbe_pkg::result_t out_res
);

  logic                vld_r, vld_nxt;
  i2cmbe_pkg::result_t res_r;

  assign adv       = !vld_r || !out_stall;
  assign out_valid = vld_r;
  assign out_res   = res_r;

  always_comb begin
    vld_nxt = vld_r;
    if (adv) begin
      vld_nxt = step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en) begin
      res_r <= res;
    end
  end

endmodule

// ----- hw/rtl/i2c_master_bit_engine_unit.sv -----
// I2C master bit engine.
// Input channel: one word per bus timing tick (in_valid / in_stall). A word
//   carries an optional command (start, stop, write byte, read byte, bus
//   release) and the sampled SDA level. Commands offered while busy are
//   ignored; codes above bus release are ignored too.
// Result channel: one word per input word (out_valid / out_stall) with the
//   SCL/SDA drive levels, ready/done flags, last read byte, write ack and
//   bus release status, all as they stand after that tick.
// Config: cfg_wr_en / cfg_wr_data write half_delay (each pin phase lasts
//   half_delay+1 ticks); write it only while no word is in flight.
// Flow: an accepted word is held in the input register, then stepped into the
//   state while its result is loaded into the result register, from which
//   it is offered. Throughput: one word per cycle while out_stall is low,
//   set by the combinational state update between the two registers.
// Stall: while out_stall is high the result word holds and the input
//   register fills; in_stall rises once both are full.
// Reset (synchronous, rst_n low): engine idle, SCL/SDA released high,
//   status cleared, half_delay back to 100, both registers empty.
module i2c_master_bit_engine_unit #(
  parameter int RELEASE_PULSES = 9
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // tick words in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd_valid,
  input  logic [2:0]  in_func,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_send_ack,
  input  logic        in_sda_in,
  // result words out
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_scl_out,
  output logic        out_sda_out,
  output logic        out_ready_res,
  output logic        out_done_res,
  output logic [7:0]  out_rx_byte,
  output logic        out_acked,
  output logic        out_release_ok
);

  i2cmbe_pkg::item_t   in_item, item;
  i2cmbe_pkg::result_t res, out_res;
  logic                adv, step_en;

  always_comb begin
    in_item.cmd_valid = in_cmd_valid;
    in_item.func      = in_func;
    in_item.tx_byte   = in_tx_byte;
    in_item.send_ack  = in_send_ack;
    in_item.sda_in    = in_sda_in;
  end

  // input word register
  i2cmbe_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .step_en  (step_en),
    .item     (item)
  );

  // phase sequencer, one tick per step
  i2cmbe_core #(
    .RELEASE_PULSES (RELEASE_PULSES)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step_en     (step_en),
    .item        (item),
    .res         (res)
  );

  // result word register
  i2cmbe_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (step_en),
    .res       (res),
    .adv       (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_scl_out    = out_res.scl_out;
  assign out_sda_out    = out_res.sda_out;
  assign out_ready_res  = out_res.ready_res;
  assign out_done_res   = out_res.done_res;
  assign out_rx_byte    = out_res.rx_byte;
  assign out_acked      = out_res.acked;
  assign out_release_ok = out_res.release_ok;

endmodule
